>>> sv/dbs_pkg.sv
// ----------------------------------------------------------------------------
// dbs_pkg: shared constants for the depth DBSCAN clusterer
// Sizes of the point store, field widths and operation codes.
// ----------------------------------------------------------------------------
package dbs_pkg;

  // Store sizes.
  localparam int MAX_POINTS  = 1024;
  localparam int DEPTH_BITS  = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int QUEUE_SLOTS = 2 * MAX_POINTS;
  localparam int Q_W         = $clog2(QUEUE_SLOTS);

  // A label entry is a cluster number with an extra flag bit for unclassified.
  localparam int LE_W  = CNT_W + 1;
  localparam int SQ_W  = 2 * DEPTH_BITS;
  localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;

  localparam logic [LE_W-1:0] CODE_NOISE = '0;
  localparam logic [LE_W-1:0] CODE_UNCL  = {1'b1, {CNT_W{1'b0}}};

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Result kinds.
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  localparam logic REG_EPS_SQUARED = 1'b0;
  localparam logic REG_MIN_POINTS  = 1'b1;

endpackage

>>> sv/dbs_in_if.sv
// ----------------------------------------------------------------------------
// dbs_in_if: input channel of the depth DBSCAN clusterer
// Carries one command transaction with its payload fields.
// ----------------------------------------------------------------------------
interface dbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] depth_mm;
  logic [9:0]  point_index;

  modport source (output valid, operation, depth_mm, point_index, input ready);
  modport sink (input valid, operation, depth_mm, point_index, output ready);
endinterface

>>> sv/dbs_out_if.sv
// ----------------------------------------------------------------------------
// dbs_out_if: result channel of the depth DBSCAN clusterer
// Carries one result transaction with its payload fields.
// ----------------------------------------------------------------------------
interface dbs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [10:0] label;
  logic        index_valid;
  logic [10:0] cluster_count;
  logic [10:0] noise_count;

  modport source (output valid, result_kind, label, index_valid, cluster_count,
                  noise_count, input ready);
  modport sink (input valid, result_kind, label, index_valid, cluster_count,
                noise_count, output ready);
endinterface

>>> sv/dbs_ram.sv
// ----------------------------------------------------------------------------
// dbs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/depth_dbscan_clusterer_core.sv
// ----------------------------------------------------------------------------
// depth_dbscan_clusterer_core: DBSCAN clustering of one-dimensional depths
// Point store, label store and seed queue in RAM, walked by one sequencer.
// ----------------------------------------------------------------------------
// A load transaction leaves the block ready again at once; a read transaction
// reads the label RAM and then waits for the result slot if it is occupied.
// A run is carried out by one shared distance unit (subtract, square, compare)
// that visits one stored point per pass through its read, square and evaluate
// states. A run first marks all labels unclassified. It then scans once for
// each point still unclassified when the walk reaches it, once more to label
// the neighbors of each core point that starts a cluster, and for every seed
// taken from the queue once to count its neighbors and once more when that
// seed is core. A point enters the queue at most once per cluster, so the
// number of scans grows with N and with the clusters found, and a run is at
// least quadratic in N. A final pass counts the noise points. The block is
// not ready while a run is in progress.
// Scans are bound by the single read port of the depth and label RAMs.
module depth_dbscan_clusterer_core (
  input  logic            clk,
  input  logic            rst,
  dbs_in_if.sink          in_ch,
  dbs_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_READ_RD, S_READ_DONE, S_INIT, S_P_NEXT, S_P_RD, S_P_CHK,
    S_SC_RD, S_SC_MUL, S_SC_EVAL, S_H_DONE, S_Q_CHK, S_Q_RD, S_Q_DATA,
    S_C_LAT, S_N_RD, S_N_EVAL, S_DONE
  } state_t;

  typedef enum logic [1:0] {M_HOOD, M_SEED, M_GROW} mode_t;

  state_t                         state;
  mode_t                          mode;
  logic                           center_is_p;
  logic [31:0]                    eps_squared;
  logic [10:0]                    min_points;
  logic [dbs_pkg::CNT_W-1:0]      point_count;
  logic [dbs_pkg::CNT_W-1:0]      clusters_found;
  logic [dbs_pkg::CNT_W-1:0]      noise_total;
  logic [dbs_pkg::CNT_W-1:0]      p;
  logic [dbs_pkg::CNT_W-1:0]      j;
  logic [dbs_pkg::CNT_W-1:0]      hood_cnt;
  logic [dbs_pkg::CNT_W-1:0]      cid;
  logic [dbs_pkg::CNT_W-1:0]      noise;
  logic [dbs_pkg::Q_W:0]          head;
  logic [dbs_pkg::Q_W:0]          tail;
  logic [9:0]                     ridx;
  logic                           rvalid;
  logic [dbs_pkg::DEPTH_BITS-1:0] center;
  logic [dbs_pkg::SQ_W-1:0]       sq;
  logic [dbs_pkg::LE_W-1:0]       lbl;

  // RAM ports.
  logic                           dwe;
  logic [dbs_pkg::IDX_W-1:0]      dwaddr;
  logic [dbs_pkg::DEPTH_BITS-1:0] dwdata;
  logic [dbs_pkg::DEPTH_BITS-1:0] drdata;
  logic                           lwe;
  logic [dbs_pkg::IDX_W-1:0]      lwaddr;
  logic [dbs_pkg::LE_W-1:0]       lwdata;
  logic [dbs_pkg::LE_W-1:0]       lrdata;
  logic [dbs_pkg::IDX_W-1:0]      raddr;
  logic                           qwe;
  logic [dbs_pkg::IDX_W-1:0]      qrdata;

  logic                           in_fire;
  logic                           near;
  logic [dbs_pkg::DEPTH_BITS-1:0] diff;
  logic                           can_push;
  logic                           out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign near        = dbs_pkg::CMP_W'(sq) <= dbs_pkg::CMP_W'(eps_squared);
  assign diff        = (center > drdata) ? (center - drdata) : (drdata - center);
  assign can_push    = 32'(tail) < 32'(dbs_pkg::QUEUE_SLOTS);

  // RAM address and write selection by sequencer state.
  always_comb begin
    dwe    = 1'b0;
    dwaddr = point_count[dbs_pkg::IDX_W-1:0];
    dwdata = dbs_pkg::DEPTH_BITS'(in_ch.depth_mm);
    lwe    = 1'b0;
    lwaddr = j[dbs_pkg::IDX_W-1:0];
    lwdata = {1'b0, cid};
    raddr  = j[dbs_pkg::IDX_W-1:0];
    qwe    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire && in_ch.operation == dbs_pkg::OP_LOAD &&
            32'(point_count) < 32'(dbs_pkg::MAX_POINTS)) begin
          dwe    = 1'b1;
          lwe    = 1'b1;
          lwaddr = point_count[dbs_pkg::IDX_W-1:0];
          lwdata = dbs_pkg::CODE_UNCL;
        end
      end
      S_READ_RD, S_READ_DONE: raddr = dbs_pkg::IDX_W'(ridx);
      S_INIT: begin
        lwe    = 1'b1;
        lwdata = dbs_pkg::CODE_UNCL;
      end
      S_P_RD: raddr = p[dbs_pkg::IDX_W-1:0];
      S_H_DONE: begin
        if (center_is_p && 32'(hood_cnt) < 32'(min_points)) begin
          lwe    = 1'b1;
          lwaddr = p[dbs_pkg::IDX_W-1:0];
          lwdata = dbs_pkg::CODE_NOISE;
        end
      end
      S_Q_DATA: raddr = qrdata;
      S_SC_EVAL: begin
        if (near) begin
          case (mode)
            M_SEED: begin
              lwe = 1'b1;
              qwe = can_push;
            end
            M_GROW: begin
              if (lbl == dbs_pkg::CODE_UNCL) begin
                lwe = 1'b1;
                qwe = can_push;
              end else if (lbl == dbs_pkg::CODE_NOISE) begin
                lwe = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= M_HOOD;
      center_is_p    <= 1'b1;
      eps_squared    <= 32'd10000;
      min_points     <= 11'd4;
      point_count    <= '0;
      clusters_found <= '0;
      noise_total    <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      // Configuration writes.
      if (cfg_we) begin
        if (cfg_index == dbs_pkg::REG_EPS_SQUARED) begin
          eps_squared <= cfg_data;
        end else begin
          min_points <= cfg_data[10:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.operation)
              dbs_pkg::OP_LOAD: begin
                if (32'(point_count) < 32'(dbs_pkg::MAX_POINTS)) begin
                  point_count <= point_count + 1'b1;
                end
              end
              dbs_pkg::OP_RUN: begin
                j     <= '0;
                p     <= '0;
                cid   <= dbs_pkg::CNT_W'(1);
                state <= (point_count == '0) ? S_P_NEXT : S_INIT;
              end
              dbs_pkg::OP_READ: begin
                ridx   <= in_ch.point_index;
                rvalid <= 32'(in_ch.point_index) < 32'(point_count);
                state  <= S_READ_RD;
              end
              default: ;
            endcase
          end
        end
        S_READ_RD: state <= S_READ_DONE;
        S_READ_DONE: begin
          if (out_free) begin
            out_ch.valid         <= 1'b1;
            out_ch.result_kind   <= dbs_pkg::KIND_READ;
            out_ch.index_valid   <= rvalid;
            out_ch.label         <= (!rvalid || lrdata == dbs_pkg::CODE_UNCL) ? 11'd0 :
                                    11'(lrdata[dbs_pkg::CNT_W-1:0]);
            out_ch.cluster_count <= 11'(clusters_found);
            out_ch.noise_count   <= 11'(noise_total);
            state                <= S_IDLE;
          end
        end
        // Mark every stored point unclassified.
        S_INIT: begin
          j <= j + 1'b1;
          if (j + 1'b1 >= point_count) begin
            state <= S_P_NEXT;
          end
        end
        // Walk the points in order, starting a cluster at each new core point.
        S_P_NEXT: begin
          if (p < point_count) begin
            state <= S_P_RD;
          end else begin
            j     <= '0;
            noise <= '0;
            state <= (point_count == '0) ? S_DONE : S_N_RD;
          end
        end
        S_P_RD: state <= S_P_CHK;
        S_P_CHK: begin
          if (lrdata != dbs_pkg::CODE_UNCL) begin
            p     <= p + 1'b1;
            state <= S_P_NEXT;
          end else begin
            center      <= drdata;
            center_is_p <= 1'b1;
            mode        <= M_HOOD;
            hood_cnt    <= '0;
            j           <= '0;
            state       <= S_SC_RD;
          end
        end
        // One neighbor per pass through the distance unit.
        S_SC_RD: state <= S_SC_MUL;
        S_SC_MUL: begin
          sq    <= dbs_pkg::SQ_W'(diff) * dbs_pkg::SQ_W'(diff);
          lbl   <= lrdata;
          state <= S_SC_EVAL;
        end
        S_SC_EVAL: begin
          if (near && mode == M_HOOD) begin
            hood_cnt <= hood_cnt + 1'b1;
          end
          if (qwe) begin
            tail <= tail + 1'b1;
          end
          j <= j + 1'b1;
          if (j + 1'b1 < point_count) begin
            state <= S_SC_RD;
          end else if (mode == M_HOOD) begin
            state <= S_H_DONE;
          end else begin
            state <= S_Q_CHK;
          end
        end
        // Decide on a finished neighborhood count.
        S_H_DONE: begin
          j <= '0;
          if (32'(hood_cnt) < 32'(min_points)) begin
            if (center_is_p) begin
              p     <= p + 1'b1;
              state <= S_P_NEXT;
            end else begin
              state <= S_Q_CHK;
            end
          end else begin
            if (center_is_p) begin
              mode <= M_SEED;
              head <= '0;
              tail <= '0;
            end else begin
              mode <= M_GROW;
            end
            state <= S_SC_RD;
          end
        end
        // Drain the seed queue breadth first.
        S_Q_CHK: begin
          if (head < tail) begin
            state <= S_Q_RD;
          end else begin
            cid   <= cid + 1'b1;
            p     <= p + 1'b1;
            state <= S_P_NEXT;
          end
        end
        S_Q_RD: begin
          head  <= head + 1'b1;
          state <= S_Q_DATA;
        end
        S_Q_DATA: state <= S_C_LAT;
        S_C_LAT: begin
          center      <= drdata;
          center_is_p <= 1'b0;
          mode        <= M_HOOD;
          hood_cnt    <= '0;
          j           <= '0;
          state       <= S_SC_RD;
        end
        // Count the points left as noise.
        S_N_RD: state <= S_N_EVAL;
        S_N_EVAL: begin
          if (lrdata == dbs_pkg::CODE_NOISE) begin
            noise <= noise + 1'b1;
          end
          j <= j + 1'b1;
          if (j + 1'b1 >= point_count) begin
            state <= S_DONE;
          end else begin
            state <= S_N_RD;
          end
        end
        S_DONE: begin
          clusters_found <= cid - 1'b1;
          noise_total    <= noise;
          if (out_free) begin
            out_ch.valid         <= 1'b1;
            out_ch.result_kind   <= dbs_pkg::KIND_RUN;
            out_ch.index_valid   <= 1'b0;
            out_ch.label         <= 11'd0;
            out_ch.cluster_count <= 11'(cid - 1'b1);
            out_ch.noise_count   <= 11'(noise);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Point depths.
  dbs_ram #(.WIDTH(dbs_pkg::DEPTH_BITS), .DEPTH(dbs_pkg::MAX_POINTS)) u_depth (
    .clk(clk), .we(dwe), .waddr(dwaddr), .wdata(dwdata),
    .raddr(raddr), .rdata(drdata)
  );

  // Point labels.
  dbs_ram #(.WIDTH(dbs_pkg::LE_W), .DEPTH(dbs_pkg::MAX_POINTS)) u_label (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
    .raddr(raddr), .rdata(lrdata)
  );

  // Seed queue.
  dbs_ram #(.WIDTH(dbs_pkg::IDX_W), .DEPTH(dbs_pkg::QUEUE_SLOTS)) u_queue (
    .clk(clk), .we(qwe), .waddr(tail[dbs_pkg::Q_W-1:0]),
    .wdata(j[dbs_pkg::IDX_W-1:0]), .raddr(head[dbs_pkg::Q_W-1:0]), .rdata(qrdata)
  );

endmodule

>>> tb/depth_dbscan_clusterer_core_test.sv
// ----------------------------------------------------------------------------
// depth_dbscan_clusterer_core_test: self-checking bench for the depth clusterer
// Drives load, run and label read transactions through the channel interfaces
// and compares every result with a built-in DBSCAN predictor, over several
// threshold settings and random idle bursts on both sides.
// ----------------------------------------------------------------------------
module depth_dbscan_clusterer_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_NONE = 2'd3;
  // Label code for a point not yet visited by a run.
  localparam int LBL_UNCL = -1;
  // Point count kept during the random part so that runs stay short.
  localparam int RANDOM_POINT_CAP = 48;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] label;
    logic        index_valid;
    logic [10:0] cluster_count;
    logic [10:0] noise_count;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] depth;
    logic [9:0]  idx;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  dbs_in_if  in_ch ();
  dbs_out_if out_ch ();

  depth_dbscan_clusterer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: stored depths, labels and the last run's totals.
  logic [15:0] depth_mem [dbs_pkg::MAX_POINTS];
  int          label_mem [dbs_pkg::MAX_POINTS];
  int          seed_fifo [dbs_pkg::QUEUE_SLOTS];
  int          pred_count;
  int          pred_clusters;
  int          pred_noise;
  logic [31:0] pred_eps_sq;
  logic [10:0] pred_min_pts;

  result_t     pending_results [$];
  stim_row_t   stim_rows [$];
  int          mismatches;
  int          results_seen;
  int          runs_sent;
  int          reads_sent;
  int          loads_sent;
  bit          gaps_on;
  bit          hold_req;
  int          hold_left;
  int          stall_left;

  // Clock; the single reset pulse is driven by the main sequence.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit depth_near(logic [15:0] a, logic [15:0] b);
    logic [63:0] d;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    return (d * d) <= 64'(pred_eps_sq);
  endfunction

  function automatic int hood_count(int p);
    int c;
    c = 0;
    for (int j = 0; j < pred_count; j++)
      if (depth_near(depth_mem[p], depth_mem[j])) c++;
    return c;
  endfunction

  // Full DBSCAN pass over the stored depths.
  function automatic void cluster_points();
    int id;
    int head;
    int tail;
    int q;
    id = 1;
    for (int i = 0; i < pred_count; i++) label_mem[i] = LBL_UNCL;
    for (int p = 0; p < pred_count; p++) begin
      if (label_mem[p] != LBL_UNCL) continue;
      if (hood_count(p) < int'(pred_min_pts)) begin
        label_mem[p] = 0;
        continue;
      end
      head = 0;
      tail = 0;
      // Every neighbor of the first core point takes the new number.
      for (int j = 0; j < pred_count; j++)
        if (depth_near(depth_mem[p], depth_mem[j])) begin
          label_mem[j] = id;
          if (tail < dbs_pkg::QUEUE_SLOTS) begin
            seed_fifo[tail] = j;
            tail++;
          end
        end
      // Grow breadth-first through the seeds.
      while (head < tail) begin
        q = seed_fifo[head];
        head++;
        if (q >= pred_count || hood_count(q) < int'(pred_min_pts)) continue;
        for (int j = 0; j < pred_count; j++) begin
          if (!depth_near(depth_mem[q], depth_mem[j])) continue;
          if (label_mem[j] == LBL_UNCL) begin
            if (tail < dbs_pkg::QUEUE_SLOTS) begin
              seed_fifo[tail] = j;
              tail++;
            end
            label_mem[j] = id;
          end else if (label_mem[j] == 0) begin
            label_mem[j] = id;
          end
        end
      end
      id++;
    end
    pred_noise = 0;
    for (int i = 0; i < pred_count; i++)
      if (label_mem[i] == 0) pred_noise++;
    pred_clusters = id - 1;
  endfunction

  // Advances the predictor by one accepted command; returns 1 with a result.
  function automatic bit predict_command(logic [1:0] op, logic [15:0] depth,
                                         logic [9:0] idx, output result_t res);
    res = '0;
    case (op)
      dbs_pkg::OP_LOAD: begin
        if (pred_count < dbs_pkg::MAX_POINTS) begin
          depth_mem[pred_count] = depth;
          label_mem[pred_count] = LBL_UNCL;
          pred_count++;
        end
        return 1'b0;
      end
      dbs_pkg::OP_RUN: begin
        cluster_points();
        res.result_kind   = dbs_pkg::KIND_RUN;
        res.cluster_count = 11'(pred_clusters);
        res.noise_count   = 11'(pred_noise);
        return 1'b1;
      end
      dbs_pkg::OP_READ: begin
        res.result_kind   = dbs_pkg::KIND_READ;
        res.cluster_count = 11'(pred_clusters);
        res.noise_count   = 11'(pred_noise);
        if (int'(idx) < pred_count) begin
          res.index_valid = 1'b1;
          res.label = (label_mem[idx] == LBL_UNCL) ? 11'd0 : 11'(label_mem[idx]);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Appends one row to the directed stimulus table.
  function automatic void add_row(logic [1:0] op, logic [15:0] depth, logic [9:0] idx,
                                  bit typed = 1'b0, result_t res = '0);
    stim_rows.insert(stim_rows.size(), '{op, depth, idx, typed, res});
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.result_kind, out_ch.label, out_ch.index_valid,
              out_ch.cluster_count, out_ch.noise_count};
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", got.result_kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind != want.result_kind)
          report_mismatch("result_kind", got.result_kind, want.result_kind);
        if (got.label != want.label)
          report_mismatch("label", got.label, want.label);
        if (got.index_valid != want.index_valid)
          report_mismatch("index_valid", got.index_valid, want.index_valid);
        if (got.cluster_count != want.cluster_count)
          report_mismatch("cluster_count", got.cluster_count, want.cluster_count);
        if (got.noise_count != want.noise_count)
          report_mismatch("noise_count", got.noise_count, want.noise_count);
      end
    end
  end

  // Result-side ready: random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req && hold_left == 0) hold_left = LONG_HOLD_CYCLES;
      hold_req = 1'b0;
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!gaps_on) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offers one command transaction and records what it should produce.
  task automatic send_command(logic [1:0] op, logic [15:0] depth, logic [9:0] idx,
                              bit typed = 1'b0, result_t typed_res = '0);
    result_t res;
    bit      has_res;
    int      n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.depth_mm    <= depth;
    in_ch.point_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    has_res = predict_command(op, depth, idx, res);
    if (has_res)
      pending_results.insert(pending_results.size(), typed ? typed_res : res);
    case (op)
      dbs_pkg::OP_LOAD: loads_sent++;
      dbs_pkg::OP_RUN:  runs_sent++;
      dbs_pkg::OP_READ: reads_sent++;
      default: ;
    endcase
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every expected result is in, then lets the block settle.
  task automatic drain();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic index, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (index == dbs_pkg::REG_EPS_SQUARED) pred_eps_sq = value;
    else pred_min_pts = value[10:0];
  endtask

  // Depth near one of four centers, with an occasional random or extreme value, so that clusters actually form.
  function automatic logic [15:0] pick_depth(logic [15:0] centers[4], int spread);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return centers[$urandom_range(0, 3)] + 16'($urandom_range(0, spread));
    endcase
  endfunction

  // Random commands, mostly loads and reads, with an occasional run or ignored code.
  task automatic random_phase(int count, int spread);
    logic [15:0] centers[4];
    int          sel;
    for (int c = 0; c < 4; c++) centers[c] = 16'($urandom_range(0, 65535));
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40 && pred_count < RANDOM_POINT_CAP)
        send_command(dbs_pkg::OP_LOAD, pick_depth(centers, spread), 10'($urandom));
      else if (sel < 46)
        send_command(dbs_pkg::OP_RUN, 16'($urandom), 10'($urandom));
      else if (sel < 49)
        send_command(OP_NONE, 16'($urandom), 10'($urandom));
      else if (sel < 75)
        send_command(dbs_pkg::OP_READ, 16'($urandom), 10'($urandom_range(0, 1023)));
      else
        send_command(dbs_pkg::OP_READ, 16'($urandom),
                     10'($urandom_range(0, (pred_count > 0) ? pred_count : 0)));
    end
  endtask

  // Run limit.
  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [31:0] eps_set [6];
    logic [31:0] min_set [6];
    int          spread_set [6];

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = 1'b0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = dbs_pkg::OP_LOAD;
    in_ch.depth_mm    = '0;
    in_ch.point_index = '0;
    out_ch.ready      = 1'b0;
    mismatches        = 0;
    results_seen      = 0;
    runs_sent         = 0;
    reads_sent        = 0;
    loads_sent        = 0;
    gaps_on           = 1'b1;
    hold_req          = 1'b0;
    hold_left         = 0;
    stall_left        = 0;
    pred_count        = 0;
    pred_clusters     = 0;
    pred_noise        = 0;
    pred_eps_sq       = 32'd10000;
    pred_min_pts      = 11'd4;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: empty store, extremes, ignored code, reads after a run.
    add_row(dbs_pkg::OP_READ, 16'd0, 10'd0, 1'b1,
            '{dbs_pkg::KIND_READ, 11'd0, 1'b0, 11'd0, 11'd0});
    add_row(dbs_pkg::OP_RUN, 16'd0, 10'd0, 1'b1,
            '{dbs_pkg::KIND_RUN, 11'd0, 1'b0, 11'd0, 11'd0});
    add_row(OP_NONE, 16'hFFFF, 10'h3FF);
    add_row(dbs_pkg::OP_LOAD, 16'd0, 10'd0);
    add_row(dbs_pkg::OP_LOAD, 16'hFFFF, 10'h3FF);
    add_row(dbs_pkg::OP_LOAD, 16'd100, 10'd0);
    add_row(dbs_pkg::OP_LOAD, 16'd150, 10'd0);
    add_row(dbs_pkg::OP_LOAD, 16'd180, 10'd0);
    add_row(dbs_pkg::OP_LOAD, 16'd65500, 10'd0);
    add_row(dbs_pkg::OP_READ, 16'd0, 10'd3, 1'b1,
            '{dbs_pkg::KIND_READ, 11'd0, 1'b1, 11'd0, 11'd0});
    add_row(dbs_pkg::OP_RUN, 16'd0, 10'd0);
    for (int i = 0; i < 6; i++) add_row(dbs_pkg::OP_READ, 16'd0, 10'(i));
    add_row(dbs_pkg::OP_READ, 16'd0, 10'd6);
    add_row(dbs_pkg::OP_READ, 16'd0, 10'h3FF);
    add_row(dbs_pkg::OP_LOAD, 16'd200, 10'd0);
    add_row(dbs_pkg::OP_READ, 16'd0, 10'd6);
    add_row(dbs_pkg::OP_RUN, 16'd0, 10'd0);
    add_row(dbs_pkg::OP_READ, 16'd0, 10'd6);
    foreach (stim_rows[r]) send_command(stim_rows[r].op, stim_rows[r].depth,
                                        stim_rows[r].idx, stim_rows[r].typed,
                                        stim_rows[r].res);
    drain();

    // Long result-side hold while reads keep coming, so the block backs up.
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++)
      send_command(dbs_pkg::OP_READ, 16'd0, 10'($urandom_range(0, 7)));
    drain();

    // Random phases over a range of thresholds, extremes included.
    eps_set    = '{32'd10000, 32'd0, 32'hFFFFFFFF, 32'd400, 32'd2500, 32'd90000};
    min_set    = '{32'd4, 32'd1, 32'd1024, 32'd0, 32'd3, 32'd2};
    spread_set = '{200, 8, 65535, 60, 150, 900};
    for (int ph = 0; ph < 6; ph++) begin
      write_register(dbs_pkg::REG_EPS_SQUARED, ph == 5 ? $urandom : eps_set[ph]);
      write_register(dbs_pkg::REG_MIN_POINTS,
                     ph == 5 ? 32'($urandom_range(1, 8)) : min_set[ph]);
      random_phase(70, spread_set[ph]);
      send_command(dbs_pkg::OP_RUN, 16'd0, 10'd0);
      drain();
    end

    // Last part without idling: more loads, one run, then reads back to back.
    gaps_on = 1'b0;
    for (int k = 0; k < 20; k++)
      send_command(dbs_pkg::OP_LOAD, 16'($urandom_range(0, 2000)), 10'($urandom));
    send_command(dbs_pkg::OP_RUN, 16'd0, 10'd0);
    send_command(dbs_pkg::OP_READ, 16'd0, 10'h3FF);
    for (int k = 0; k < 30; k++)
      send_command(dbs_pkg::OP_READ, 16'd0, 10'($urandom_range(0, 1023)));
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d loads, %0d runs and %0d label reads; %0d results checked.",
             loads_sent, runs_sent, reads_sent, results_seen);
    $display("Thresholds from 0 to the maximum, core sizes 0 to 1024, store held %0d points.",
             pred_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
sv/dbs_pkg.sv
sv/dbs_in_if.sv
sv/dbs_out_if.sv
sv/dbs_ram.sv
sv/depth_dbscan_clusterer_core.sv
tb/depth_dbscan_clusterer_core_test.sv
